// ===== hw/rtl/bpl_pkg.sv =====
package bpl_pkg;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int LEVEL_W    = 16;
  localparam int PHASE_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL   = 3'd4;

  localparam logic [16:0]        PRESCALE_RST     = 17'd84;
  localparam logic [16:0]        PERIOD_RST       = 17'd1000;
  localparam logic [LEVEL_W-1:0] RAMP_STEP_RST    = 16'd1;
  localparam logic [LEVEL_W-1:0] PAUSE_LENGTH_RST = 16'd500;
  localparam logic [LEVEL_W-1:0] PEAK_LEVEL_RST   = 16'd1000;

  localparam logic [LEVEL_W-1:0] HOLD_MAX = 16'hFFFF;

  localparam logic [PHASE_W-1:0] PH_RISE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_TOP    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_FALL   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_BOTTOM = 2'd3;

  typedef struct packed {
    logic               pwm_out;
    logic [LEVEL_W-1:0] duty_level;
    logic [PHASE_W-1:0] breath_phase;
    logic               cycle_end;
  } result_t;

endpackage

// ===== hw/rtl/breathing_pwm_led.sv =====
// channel | ports                                                    | dir
// --------+----------------------------------------------------------+----
// input   | in_valid, in_stall, in_tick                              | in
// result  | out_valid, out_stall, out_pwm_out, out_duty_level,       | out
//         | out_breath_phase, out_cycle_end                          |
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data                | in
//
// one beat in, one beat out; one beat per clock is sustained while in_stall
// is low, as the counter and phase update are computed combinationally.
// the result sits in an output register backed by a one-entry skid register;
// in_stall rises only when both are full and out_stall holds.
// rst_n (synchronous) clears the counters, level, duty, phase and buffers and
// loads the register defaults; cfg_ready is always high.
module breathing_pwm_led
  import bpl_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_tick,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pwm_out,
  output logic [LEVEL_W-1:0]    out_duty_level,
  output logic [PHASE_W-1:0]    out_breath_phase,
  output logic                  out_cycle_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = COUNTER_WIDTH;
  localparam int DW   = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam int CMPW = (CW > LEVEL_W) ? CW : LEVEL_W;
  localparam logic [DW-1:0] CNT_LIMIT = DW'(1) << CW;

  logic [CFG_DATA_W-1:0] prescale_r, period_r;
  logic [LEVEL_W-1:0]    ramp_step_r, pause_length_r, peak_level_r;

  logic [CW-1:0]      prescale_count_r, prescale_count_nxt;
  logic [CW-1:0]      period_count_r, period_count_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [LEVEL_W-1:0] active_duty_r, active_duty_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [LEVEL_W-1:0] hold_count_r, hold_count_nxt;

  result_t out_data_r, skid_data_r, res_nxt;
  logic    out_valid_r, skid_full_r;

  logic          accept, out_take, wrapped;
  logic [DW-1:0] div_pre, div_per;
  logic [CW:0]   pre_inc, per_inc;
  logic [LEVEL_W:0]   rise_sum;
  logic [LEVEL_W-1:0] hold_inc;

  function automatic logic [DW-1:0] clamp_div(input logic [CFG_DATA_W-1:0] v);
    logic [DW-1:0] d;
    d = DW'(v);
    if (d == '0) begin
      d = DW'(1);
    end else if (d > CNT_LIMIT) begin
      d = CNT_LIMIT;
    end
    return d;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full_r;
  assign accept    = in_valid && !skid_full_r;
  assign out_take  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r     <= PRESCALE_RST;
      period_r       <= PERIOD_RST;
      ramp_step_r    <= RAMP_STEP_RST;
      pause_length_r <= PAUSE_LENGTH_RST;
      peak_level_r   <= PEAK_LEVEL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PRESCALE:     prescale_r     <= cfg_data;
        CFG_PERIOD:       period_r       <= cfg_data;
        CFG_RAMP_STEP:    ramp_step_r    <= cfg_data[LEVEL_W-1:0];
        CFG_PAUSE_LENGTH: pause_length_r <= cfg_data[LEVEL_W-1:0];
        CFG_PEAK_LEVEL:   peak_level_r   <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_pre  = clamp_div(prescale_r);
    div_per  = clamp_div(period_r);
    pre_inc  = {1'b0, prescale_count_r} + (CW+1)'(1);
    per_inc  = {1'b0, period_count_r} + (CW+1)'(1);
    rise_sum = {1'b0, level_r} + {1'b0, ramp_step_r};
    hold_inc = (hold_count_r < HOLD_MAX) ? hold_count_r + LEVEL_W'(1) : hold_count_r;

    prescale_count_nxt = prescale_count_r;
    period_count_nxt   = period_count_r;
    level_nxt          = level_r;
    active_duty_nxt    = active_duty_r;
    phase_nxt          = phase_r;
    hold_count_nxt     = hold_count_r;
    wrapped            = 1'b0;

    if (accept && in_tick) begin
      if (DW'(pre_inc) >= div_pre) begin
        prescale_count_nxt = '0;
        if (DW'(per_inc) >= div_per) begin
          period_count_nxt = '0;
          wrapped          = 1'b1;
          active_duty_nxt  = level_r;
          case (phase_r)
            PH_RISE: begin
              if (rise_sum >= {1'b0, peak_level_r}) begin
                level_nxt      = peak_level_r;
                phase_nxt      = PH_TOP;
                hold_count_nxt = '0;
              end else begin
                level_nxt = rise_sum[LEVEL_W-1:0];
              end
            end
            PH_TOP: begin
              hold_count_nxt = hold_inc;
              if (hold_inc >= pause_length_r) phase_nxt = PH_FALL;
            end
            PH_FALL: begin
              if (level_r <= ramp_step_r) begin
                level_nxt      = '0;
                phase_nxt      = PH_BOTTOM;
                hold_count_nxt = '0;
              end else begin
                level_nxt = level_r - ramp_step_r;
              end
            end
            default: begin
              hold_count_nxt = hold_inc;
              if (hold_inc >= pause_length_r) phase_nxt = PH_RISE;
            end
          endcase
        end else begin
          period_count_nxt = per_inc[CW-1:0];
        end
      end else begin
        prescale_count_nxt = pre_inc[CW-1:0];
      end
    end

    res_nxt.pwm_out      = CMPW'(period_count_nxt) < CMPW'(active_duty_nxt);
    res_nxt.duty_level   = level_nxt;
    res_nxt.breath_phase = phase_nxt;
    res_nxt.cycle_end    = wrapped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_count_r <= '0;
      period_count_r   <= '0;
      level_r          <= '0;
      active_duty_r    <= '0;
      phase_r          <= PH_RISE;
      hold_count_r     <= '0;
    end else begin
      prescale_count_r <= prescale_count_nxt;
      period_count_r   <= period_count_nxt;
      level_r          <= level_nxt;
      active_duty_r    <= active_duty_nxt;
      phase_r          <= phase_nxt;
      hold_count_r     <= hold_count_nxt;
    end
  end

  // output register with one-entry skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_full_r <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_full_r) begin
          skid_full_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= res_nxt;
      end else begin
        skid_data_r <= res_nxt;
      end
    end else if (out_take && skid_full_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pwm_out      = out_data_r.pwm_out;
  assign out_duty_level   = out_data_r.duty_level;
  assign out_breath_phase = out_data_r.breath_phase;
  assign out_cycle_end    = out_data_r.cycle_end;

endmodule
